@@ rtl/fpha_pkg.sv @@
// Shared types, codes and defaults of the fit-policy hole allocator.
package fpha_pkg;

   // Default sizing of the hole row
   localparam int NUM_HOLES_DEF  = 16;
   localparam int SIZE_WIDTH_DEF = 16;

   // Fixed field widths of the ports
   localparam int IDX_FIELD_W = 4;
   localparam int DATA_W      = 16;
   localparam int CSR_DATA_W  = 5;
   localparam int CSR_IDX_W   = 1;
   localparam int COUNT_W     = 5;
   localparam int POLICY_W    = 2;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_FIT_POLICY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLE_COUNT = 1'b1;

   // Operation of an input item
   typedef enum logic [1:0] {
      MODE_LOAD  = 2'd0,
      MODE_CLEAR = 2'd1,
      MODE_PLACE = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   // Placement rules; the unused code falls back to first fit
   typedef enum logic [POLICY_W-1:0] {
      FIT_FIRST = 2'd0,
      FIT_BEST  = 2'd1,
      FIT_WORST = 2'd2
   } policy_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPORT
   } state_type;

   // Write operation broadcast to the cells
   typedef enum logic [1:0] {
      CELL_NOP,
      CELL_LOAD,
      CELL_CLEAR,
      CELL_GRANT
   } cell_op_type;

   // Per-cell control from the sequencer
   typedef struct packed {
      cell_op_type           op;
      logic                  sel;
      logic                  in_scope;
      logic                  read_mode;
      logic [POLICY_W-1:0]   policy;
   } cell_ctl_type;

   // Flags of the token that walks the cell row
   typedef struct packed {
      logic valid;
      logic found;
      logic used;
   } tok_flags_type;

   // Input item
   typedef struct packed {
      mode_type                 mode;
      logic [IDX_FIELD_W-1:0]   hole_index;
      logic [DATA_W-1:0]        hole_size;
      logic [DATA_W-1:0]        page_name;
      logic [DATA_W-1:0]        page_size;
   } req_item_type;

   // Result item
   typedef struct packed {
      logic                     placed;
      logic [IDX_FIELD_W-1:0]   chosen_hole;
      logic [DATA_W-1:0]        leftover;
      logic [DATA_W-1:0]        owner_page;
      logic [DATA_W-1:0]        consumed_size;
      logic                     hole_used;
   } rsp_item_type;

endpackage

@@ rtl/fpha_stream_if.sv @@
// Valid/ready item channel used for requests and responses.
interface fpha_stream_if #(
   parameter type item_type = logic
);
   logic     valid;
   logic     ready;
   item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/fit_policy_hole_allocator.sv @@
// Top level of the fit-policy hole allocator: sequencer, registers and cell row.
// The holes live in a row of NUM_HOLES cells. A place or read item sends one
// token down the row, one cell per cycle; each cell swaps in its own hole when
// it fits better under the fit_policy rule (or when it is the hole being read),
// so the last cell hands out the answer. A place or read item is launched as a
// token, walks through the row, is caught as it leaves the last cell and is then
// reported. Load and clear items go straight to the report; their writes are
// broadcast to every cell at once, and a load changes only the selected cell. A
// finished result sits in an output register, so the next item is taken while
// it waits. Holes are ranked only among the first hole_count entries; ties go
// to the lower index.
module fit_policy_hole_allocator
   import fpha_pkg::*;
#(
   parameter int NUM_HOLES  = NUM_HOLES_DEF,
   parameter int SIZE_WIDTH = SIZE_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   fpha_stream_if.sink           req_if,
   fpha_stream_if.source         rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(NUM_HOLES);
   localparam int SEL_W = (IDX_W > IDX_FIELD_W) ? IDX_W : IDX_FIELD_W;

   // Configuration registers
   logic [POLICY_W-1:0] policy_ff;
   logic [COUNT_W-1:0]  hole_count_ff;

   // Sequencer
   state_type state_ff, state_in;
   logic      launch_ff;
   logic      req_accept;
   logic      rsp_free;
   logic      report_fire;
   logic      capture;

   // Item held while it is worked on
   mode_type                mode_ff;
   logic [IDX_FIELD_W-1:0]  idx_ff;
   logic [SIZE_WIDTH-1:0]   hsize_ff;
   logic [DATA_W-1:0]       pname_ff;
   logic [SIZE_WIDTH-1:0]   psize_ff;

   // Token taken from the end of the row
   logic                    res_found_ff;
   logic                    res_used_ff;
   logic [IDX_W-1:0]        res_pick_ff;
   logic [SIZE_WIDTH-1:0]   res_best_ff;
   logic [DATA_W-1:0]       res_owner_ff;
   logic [SIZE_WIDTH-1:0]   res_cons_ff;

   // Output register
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff, rsp_item_in;

   // Cell row wiring
   tok_flags_type         tok_chain   [NUM_HOLES+1];
   logic [IDX_W-1:0]      pick_chain  [NUM_HOLES+1];
   logic [SIZE_WIDTH-1:0] best_chain  [NUM_HOLES+1];
   logic [DATA_W-1:0]     owner_chain [NUM_HOLES+1];
   logic [SIZE_WIDTH-1:0] cons_chain  [NUM_HOLES+1];
   logic [NUM_HOLES-1:0]  tok_valid_vec;
   cell_op_type           cell_op;
   logic [SEL_W-1:0]      sel_idx;
   logic                  idx_in_range;

   assign req_accept   = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign idx_in_range = (32'(idx_ff) < 32'(NUM_HOLES));

   // Take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff     <= FIT_FIRST;
         hole_count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIT_POLICY: policy_ff     <= csr_wdata[POLICY_W-1:0];
            CSR_HOLE_COUNT: hole_count_ff <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_if.payload.mode == MODE_PLACE || req_if.payload.mode == MODE_READ) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_REPORT;
               end
            end
         end
         ST_SCAN: begin
            if (tok_chain[NUM_HOLES].valid) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_if.ready = (state_ff == ST_IDLE);
      capture      = (state_ff == ST_SCAN) && tok_chain[NUM_HOLES].valid;
      report_fire  = (state_ff == ST_REPORT) && rsp_free;
      cell_op      = CELL_NOP;
      if (report_fire) begin
         case (mode_ff)
            MODE_LOAD:  cell_op = CELL_LOAD;
            MODE_CLEAR: cell_op = CELL_CLEAR;
            MODE_PLACE: cell_op = res_found_ff ? CELL_GRANT : CELL_NOP;
            default:    cell_op = CELL_NOP;
         endcase
      end
      sel_idx = (mode_ff == MODE_PLACE) ? SEL_W'(res_pick_ff) : SEL_W'(idx_ff);
   end

   // Hold state, launch the token once after a place or read is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         launch_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= req_accept &&
                      (req_if.payload.mode == MODE_PLACE || req_if.payload.mode == MODE_READ);
      end
   end

   // Latch the accepted item
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff  <= req_if.payload.mode;
         idx_ff   <= req_if.payload.hole_index;
         hsize_ff <= SIZE_WIDTH'(req_if.payload.hole_size);
         pname_ff <= req_if.payload.page_name;
         psize_ff <= SIZE_WIDTH'(req_if.payload.page_size);
      end
   end

   // Catch the token as it leaves the last cell
   always_ff @(posedge clock) begin
      if (capture) begin
         res_found_ff <= tok_chain[NUM_HOLES].found;
         res_used_ff  <= tok_chain[NUM_HOLES].used;
         res_pick_ff  <= pick_chain[NUM_HOLES];
         res_best_ff  <= best_chain[NUM_HOLES];
         res_owner_ff <= owner_chain[NUM_HOLES];
         res_cons_ff  <= cons_chain[NUM_HOLES];
      end
   end

   // Build the result item
   always_comb begin
      rsp_item_in = '0;
      case (mode_ff)
         MODE_LOAD: begin
            rsp_item_in.chosen_hole = idx_ff;
            if (idx_in_range) begin
               rsp_item_in.leftover = DATA_W'(hsize_ff);
            end
         end
         MODE_PLACE: begin
            if (res_found_ff) begin
               rsp_item_in.placed        = 1'b1;
               rsp_item_in.chosen_hole   = IDX_FIELD_W'(res_pick_ff);
               rsp_item_in.leftover      = DATA_W'(res_best_ff);
               rsp_item_in.owner_page    = pname_ff;
               rsp_item_in.consumed_size = DATA_W'(psize_ff);
               rsp_item_in.hole_used     = 1'b1;
            end
         end
         MODE_READ: begin
            rsp_item_in.chosen_hole = idx_ff;
            if (res_found_ff) begin
               rsp_item_in.leftover      = DATA_W'(res_best_ff);
               rsp_item_in.owner_page    = res_owner_ff;
               rsp_item_in.consumed_size = DATA_W'(res_cons_ff);
               rsp_item_in.hole_used     = res_used_ff;
            end
         end
         default: rsp_item_in = '0;
      endcase
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (report_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (report_fire) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_item_ff;

   // Feed an empty token into the first cell
   assign tok_chain[0]   = '{valid: launch_ff, found: 1'b0, used: 1'b0};
   assign pick_chain[0]  = '0;
   assign best_chain[0]  = '0;
   assign owner_chain[0] = '0;
   assign cons_chain[0]  = '0;

   // Row of hole cells
   for (genvar j = 0; j < NUM_HOLES; j++) begin : g_cell
      cell_ctl_type ctl;

      always_comb begin
         ctl.op        = cell_op;
         ctl.sel       = (32'(sel_idx) == 32'(j));
         ctl.in_scope  = (32'(hole_count_ff) > 32'(j));
         ctl.read_mode = (mode_ff == MODE_READ);
         ctl.policy    = policy_ff;
      end

      fpha_cell #(
         .NUM_HOLES  (NUM_HOLES),
         .SIZE_WIDTH (SIZE_WIDTH),
         .CELL_INDEX (j)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .wr_size   (hsize_ff),
         .wr_name   (pname_ff),
         .wr_psize  (psize_ff),
         .tok_in    (tok_chain[j]),
         .pick_in   (pick_chain[j]),
         .best_in   (best_chain[j]),
         .owner_in  (owner_chain[j]),
         .cons_in   (cons_chain[j]),
         .tok_out   (tok_chain[j+1]),
         .pick_out  (pick_chain[j+1]),
         .best_out  (best_chain[j+1]),
         .owner_out (owner_chain[j+1]),
         .cons_out  (cons_chain[j+1])
      );

      assign tok_valid_vec[j] = tok_chain[j+1].valid;
   end

   // At most one token walks the row
   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid_vec))
      else $error("more than one token in the cell row");

   // A token only leaves the row while a scan waits for it
   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok_chain[NUM_HOLES].valid |-> state_ff == ST_SCAN)
      else $error("token left the row outside a scan");

   // A new result is only loaded from the report state
   a_result_from_report: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_REPORT))
      else $error("result appeared without a report");

   // A blocked report keeps waiting and leaves the held result alone
   a_report_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPORT && !rsp_free) |=> (state_ff == ST_REPORT && $stable(rsp_item_ff)))
      else $error("report did not wait for the output register");

endmodule

@@ rtl/fpha_cell.sv @@
// One hole of the allocator: its entry and one stage of the search token.
module fpha_cell
   import fpha_pkg::*;
#(
   parameter int NUM_HOLES  = NUM_HOLES_DEF,
   parameter int SIZE_WIDTH = SIZE_WIDTH_DEF,
   parameter int CELL_INDEX = 0,
   localparam int IDX_W     = $clog2(NUM_HOLES)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctl_type          ctl,
   input  logic [SIZE_WIDTH-1:0] wr_size,
   input  logic [DATA_W-1:0]     wr_name,
   input  logic [SIZE_WIDTH-1:0] wr_psize,
   input  tok_flags_type         tok_in,
   input  logic [IDX_W-1:0]      pick_in,
   input  logic [SIZE_WIDTH-1:0] best_in,
   input  logic [DATA_W-1:0]     owner_in,
   input  logic [SIZE_WIDTH-1:0] cons_in,
   output tok_flags_type         tok_out,
   output logic [IDX_W-1:0]      pick_out,
   output logic [SIZE_WIDTH-1:0] best_out,
   output logic [DATA_W-1:0]     owner_out,
   output logic [SIZE_WIDTH-1:0] cons_out
);

   // Entry of this hole
   logic [SIZE_WIDTH-1:0] size_ff;
   logic                  used_ff;
   logic [DATA_W-1:0]     owner_ff;
   logic [SIZE_WIDTH-1:0] cons_ff;

   // Token stage
   tok_flags_type         tok_ff, tok_in_nxt;
   logic [IDX_W-1:0]      pick_ff, pick_in_nxt;
   logic [SIZE_WIDTH-1:0] best_ff, best_in_nxt;
   logic [DATA_W-1:0]     owner_tok_ff, owner_tok_in;
   logic [SIZE_WIDTH-1:0] cons_tok_ff, cons_tok_in;

   logic                  fits;
   logic                  better;
   logic [SIZE_WIDTH-1:0] diff;

   // Judge this hole against the best candidate so far
   always_comb begin
      fits = ctl.in_scope && !used_ff && (size_ff >= wr_psize);
      diff = size_ff - wr_psize;
      case (ctl.policy)
         FIT_BEST:  better = !tok_in.found || (diff < best_in);
         FIT_WORST: better = !tok_in.found || (diff > best_in);
         default:   better = !tok_in.found;
      endcase
   end

   // Pass the token on, replacing its payload on a better hole or a read hit
   always_comb begin
      tok_in_nxt   = tok_in;
      pick_in_nxt  = pick_in;
      best_in_nxt  = best_in;
      owner_tok_in = owner_in;
      cons_tok_in  = cons_in;
      if (ctl.read_mode) begin
         if (ctl.sel) begin
            tok_in_nxt.found = 1'b1;
            tok_in_nxt.used  = used_ff;
            best_in_nxt      = size_ff - cons_ff;
            owner_tok_in     = owner_ff;
            cons_tok_in      = cons_ff;
         end
      end else if (fits && better) begin
         tok_in_nxt.found = 1'b1;
         pick_in_nxt      = IDX_W'(CELL_INDEX);
         best_in_nxt      = diff;
      end
   end

   // Advance the token one cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_nxt;
      end
      pick_ff      <= pick_in_nxt;
      best_ff      <= best_in_nxt;
      owner_tok_ff <= owner_tok_in;
      cons_tok_ff  <= cons_tok_in;
   end

   // Apply broadcast writes to the entry
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         owner_ff <= '0;
         cons_ff  <= '0;
      end else begin
         case (ctl.op)
            CELL_LOAD: begin
               if (ctl.sel) begin
                  size_ff  <= wr_size;
                  used_ff  <= 1'b0;
                  owner_ff <= '0;
                  cons_ff  <= '0;
               end
            end
            CELL_CLEAR: begin
               used_ff  <= 1'b0;
               owner_ff <= '0;
               cons_ff  <= '0;
            end
            CELL_GRANT: begin
               if (ctl.sel) begin
                  used_ff  <= 1'b1;
                  owner_ff <= wr_name;
                  cons_ff  <= wr_psize;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign tok_out   = tok_ff;
   assign pick_out  = pick_ff;
   assign best_out  = best_ff;
   assign owner_out = owner_tok_ff;
   assign cons_out  = cons_tok_ff;

endmodule

@@ tb/fit_policy_hole_allocator_checker.sv @@
// Checker of the fit-policy hole allocator: tracks the hole table and compares each result.
module fit_policy_hole_allocator_checker
   import fpha_pkg::*;
#(
   parameter int NUM_HOLES = NUM_HOLES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_item_type          req_item,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_item_type          rsp_item,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    pending_count,
   output int                    grant_count,
   output int                    refusal_count
);

   // Shadow copy of the registers and of the hole table
   logic [POLICY_W-1:0] policy_q;
   logic [COUNT_W-1:0]  scope_q;
   logic [DATA_W-1:0]   size_q     [NUM_HOLES];
   logic                used_q     [NUM_HOLES];
   logic [DATA_W-1:0]   owner_q    [NUM_HOLES];
   logic [DATA_W-1:0]   consumed_q [NUM_HOLES];

   // Results still owed by the block, oldest first
   rsp_item_type due_reports [$];

   // Build the report of one hole; an invalid hole reports zeros apart from placed and its index
   function automatic rsp_item_type hole_report(input logic placed, input int idx,
                                                input logic valid);
      rsp_item_type r;
      r = '0;
      r.placed      = placed;
      r.chosen_hole = idx[IDX_FIELD_W-1:0];
      if (valid) begin
         r.leftover      = size_q[idx] - consumed_q[idx];
         r.owner_page    = owner_q[idx];
         r.consumed_size = consumed_q[idx];
         r.hole_used     = used_q[idx];
      end
      return r;
   endfunction

   // Search the holes in scope for one that takes the page; -1 if none fits
   function automatic int pick_hole(input logic [DATA_W-1:0] need);
      int                limit;
      int                pick;
      int                j;
      logic [DATA_W-1:0] diff;
      logic [DATA_W-1:0] best;
      limit = (scope_q > NUM_HOLES) ? NUM_HOLES : int'(scope_q);
      pick  = -1;
      best  = '0;
      for (j = 0; j < limit; j++) begin
         if (!used_q[j] && size_q[j] >= need) begin
            diff = size_q[j] - need;
            case (policy_q)
               FIT_BEST: begin
                  if (pick < 0 || diff < best) begin
                     pick = j;
                     best = diff;
                  end
               end
               FIT_WORST: begin
                  if (pick < 0 || diff > best) begin
                     pick = j;
                     best = diff;
                  end
               end
               // first fit, also for the unused policy code
               default: begin
                  if (pick < 0) pick = j;
               end
            endcase
         end
      end
      return pick;
   endfunction

   // Apply one item to the shadow table and return the result it causes
   function automatic rsp_item_type apply_item(input req_item_type it);
      rsp_item_type r;
      int           idx;
      int           k;
      int           j;
      idx = int'(it.hole_index);
      r   = '0;
      case (it.mode)
         MODE_LOAD: begin
            if (idx < NUM_HOLES) begin
               size_q[idx]     = it.hole_size;
               used_q[idx]     = 1'b0;
               owner_q[idx]    = '0;
               consumed_q[idx] = '0;
            end
            r = hole_report(1'b0, idx, idx < NUM_HOLES);
         end
         MODE_CLEAR: begin
            for (j = 0; j < NUM_HOLES; j++) begin
               used_q[j]     = 1'b0;
               owner_q[j]    = '0;
               consumed_q[j] = '0;
            end
         end
         MODE_PLACE: begin
            k = pick_hole(it.page_size);
            if (k >= 0) begin
               used_q[k]     = 1'b1;
               owner_q[k]    = it.page_name;
               consumed_q[k] = it.page_size;
               r = hole_report(1'b1, k, 1'b1);
            end
         end
         default: begin
            r = hole_report(1'b0, idx, idx < NUM_HOLES);
         end
      endcase
      return r;
   endfunction

   // Track registers and items, compare results at each rising edge
   always @(posedge clock) begin
      rsp_item_type want;
      int           j;
      if (reset) begin
         policy_q = FIT_FIRST;
         scope_q  = '0;
         for (j = 0; j < NUM_HOLES; j++) begin
            size_q[j]     = '0;
            used_q[j]     = 1'b0;
            owner_q[j]    = '0;
            consumed_q[j] = '0;
         end
         due_reports.delete();
         mismatch_count = 0;
         grant_count    = 0;
         refusal_count  = 0;
      end else begin
         // retire a result first: it always belongs to an earlier item
         if (rsp_valid && rsp_ready) begin
            if (due_reports.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result with no item waiting: placed=%0d hole=%0d",
                           $time, rsp_item.placed, rsp_item.chosen_hole);
            end else begin
               want = due_reports.pop_front();
               if (rsp_item.placed        !== want.placed        ||
                   rsp_item.chosen_hole   !== want.chosen_hole   ||
                   rsp_item.leftover      !== want.leftover      ||
                   rsp_item.owner_page    !== want.owner_page    ||
                   rsp_item.consumed_size !== want.consumed_size ||
                   rsp_item.hole_used     !== want.hole_used) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: expected placed=%0d hole=%0d leftover=%0d owner=%0d consumed=%0d used=%0d",
                              $time, want.placed, want.chosen_hole, want.leftover,
                              want.owner_page, want.consumed_size, want.hole_used);
                     $display("%0t: actual   placed=%0d hole=%0d leftover=%0d owner=%0d consumed=%0d used=%0d",
                              $time, rsp_item.placed, rsp_item.chosen_hole, rsp_item.leftover,
                              rsp_item.owner_page, rsp_item.consumed_size, rsp_item.hole_used);
                  end
               end
            end
         end
         // register writes
         if (csr_we) begin
            case (csr_index)
               CSR_FIT_POLICY: policy_q = csr_wdata[POLICY_W-1:0];
               CSR_HOLE_COUNT: scope_q  = csr_wdata[COUNT_W-1:0];
               default: ;
            endcase
         end
         // predict the accepted item
         if (req_valid && req_ready) begin
            want = apply_item(req_item);
            if (req_item.mode == MODE_PLACE) begin
               if (want.placed) grant_count++;
               else refusal_count++;
            end
            due_reports.push_back(want);
         end
      end
      pending_count = due_reports.size();
   end

endmodule

@@ tb/fit_policy_hole_allocator_test.sv @@
// Test top of the fit-policy hole allocator: clock, reset, stimulus and verdict.
module fit_policy_hole_allocator_test;
   import fpha_pkg::*;

   localparam int NUM_HOLES     = NUM_HOLES_DEF;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int PHASES        = 8;
   localparam int SETTLE_CYCLES = NUM_HOLES + 8;

   // policy code outside the enum, which the block treats as first fit
   localparam logic [POLICY_W-1:0] FIT_SPARE = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  calm;
   int                    mismatch_count;
   int                    pending_count;
   int                    grant_count;
   int                    refusal_count;
   int                    sent_count;
   logic [DATA_W-1:0]     loaded_size [NUM_HOLES];

   fpha_stream_if #(.item_type(req_item_type)) req_chan ();
   fpha_stream_if #(.item_type(rsp_item_type)) rsp_chan ();

   fit_policy_hole_allocator #(
      .NUM_HOLES  (NUM_HOLES),
      .SIZE_WIDTH (SIZE_WIDTH_DEF)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_chan),
      .rsp_if    (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   fit_policy_hole_allocator_checker #(
      .NUM_HOLES (NUM_HOLES)
   ) hole_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_item       (req_chan.payload),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_item       (rsp_chan.payload),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .grant_count    (grant_count),
      .refusal_count  (refusal_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Hard stop in case the block hangs
   initial begin
      #5_000_000;
      $display("fit_policy_hole_allocator test failed");
      $finish;
   end

   // Drop ready at random, except in the calm stretch
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready = calm || ($urandom_range(0, 99) >= 36);
      end
   end

   // Offer one item after a random gap and hold it until taken; enter and leave at a falling edge
   task automatic send_item(input req_item_type it);
      int gap;
      gap = 0;
      if (!calm) begin
         if ($urandom_range(0, 99) < 4) gap = $urandom_range(2, 24);
         else while ($urandom_range(0, 99) < 36) gap++;
      end
      repeat (gap) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.payload = it;
      req_chan.valid   = 1'b1;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      sent_count++;
      @(negedge clock);
   endtask

   // Hold the sender until every result is back and the block is idle
   task automatic settle();
      req_chan.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   initial begin
      req_item_type        it;
      int                  j;
      int                  phase;
      int                  sel;
      logic [POLICY_W-1:0] pol;
      logic [COUNT_W-1:0]  cnt;

      reset            = 1'b1;
      calm             = 1'b0;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      sent_count       = 0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // hole_count is still zero after reset, so nothing can be placed
      it = '0;
      it.mode      = MODE_PLACE;
      it.page_name = 16'h1234;
      it.page_size = 16'd5;
      send_item(it);

      // load every hole: full size, empty, tied sizes and a spread of others
      for (j = 0; j < NUM_HOLES; j++) begin
         it = '0;
         it.mode       = MODE_LOAD;
         it.hole_index = j[IDX_FIELD_W-1:0];
         case (j)
            0:       it.hole_size = 16'hFFFF;
            1:       it.hole_size = 16'd0;
            2, 4:    it.hole_size = 16'd40;
            3:       it.hole_size = 16'd300;
            5:       it.hole_size = 16'd1000;
            default: it.hole_size = 16'(j * 37 + 5);
         endcase
         loaded_size[j] = it.hole_size;
         send_item(it);
      end

      // first fit: empty page takes hole 0, then a full-size page finds nothing
      settle();
      write_reg(CSR_HOLE_COUNT, 5'd16);
      it = '0;
      it.mode      = MODE_PLACE;
      it.page_name = 16'hFFFF;
      it.page_size = 16'd0;
      send_item(it);
      it.page_size = 16'hFFFF;
      send_item(it);
      it = '0;
      it.mode = MODE_READ;
      send_item(it);

      // best fit: two exact fits tie, lower index wins
      settle();
      write_reg(CSR_FIT_POLICY, CSR_DATA_W'(FIT_BEST));
      it = '0;
      it.mode      = MODE_PLACE;
      it.page_name = 16'd2;
      it.page_size = 16'd40;
      send_item(it);

      // worst fit with a hole count beyond the table
      settle();
      write_reg(CSR_FIT_POLICY, CSR_DATA_W'(FIT_WORST));
      write_reg(CSR_HOLE_COUNT, 5'd31);
      it.page_name = 16'd3;
      send_item(it);

      // unused policy code falls back to first fit
      settle();
      write_reg(CSR_FIT_POLICY, CSR_DATA_W'(FIT_SPARE));
      it.page_name = 16'd4;
      it.page_size = 16'd1;
      send_item(it);

      it = '0;
      it.mode = MODE_CLEAR;
      send_item(it);
      it = '0;
      it.mode       = MODE_READ;
      it.hole_index = 4'd15;
      send_item(it);

      // random phases, each under its own register setting
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0:       begin pol = FIT_FIRST; cnt = 5'd16; end
            1:       begin pol = FIT_BEST;  cnt = 5'd16; end
            2:       begin pol = FIT_WORST; cnt = 5'd16; end
            3:       begin pol = FIT_SPARE; cnt = 5'd31; end
            4:       begin pol = FIT_BEST;  cnt = 5'd1;  end
            5:       begin pol = FIT_WORST; cnt = 5'd17; end
            6:       begin pol = FIT_FIRST; cnt = 5'd0;  end
            default: begin
               pol = POLICY_W'($urandom_range(0, 3));
               cnt = COUNT_W'($urandom_range(0, 31));
            end
         endcase
         write_reg(CSR_FIT_POLICY, CSR_DATA_W'(pol));
         write_reg(CSR_HOLE_COUNT, CSR_DATA_W'(cnt));
         calm = (phase == 2);

         for (j = 0; j < RANDOM_ITEMS / PHASES; j++) begin
            it = '0;
            sel = $urandom_range(0, 99);
            if (sel < 50)      it.mode = MODE_PLACE;
            else if (sel < 72) it.mode = MODE_LOAD;
            else if (sel < 92) it.mode = MODE_READ;
            else               it.mode = MODE_CLEAR;
            it.hole_index = IDX_FIELD_W'($urandom_range(0, NUM_HOLES - 1));
            it.page_name  = DATA_W'($urandom);

            // mostly small holes so that pages compete for them
            sel = $urandom_range(0, 99);
            if (sel < 70)      it.hole_size = DATA_W'($urandom_range(0, 300));
            else if (sel < 85) it.hole_size = DATA_W'($urandom);
            else if (sel < 92) it.hole_size = '1;
            else               it.hole_size = '0;

            // aim pages at exact fits part of the time
            sel = $urandom_range(0, 99);
            if (sel < 40)
               it.page_size = loaded_size[IDX_FIELD_W'($urandom_range(0, NUM_HOLES - 1))];
            else if (sel < 80) it.page_size = DATA_W'($urandom_range(0, 300));
            else if (sel < 95) it.page_size = DATA_W'($urandom);
            else               it.page_size = '0;

            if (it.mode == MODE_LOAD) loaded_size[it.hole_index] = it.hole_size;
            send_item(it);
         end
      end
      calm = 1'b0;

      // drain and let the block go quiet
      settle();

      $display("covered %0d items under %0d register settings, all four policy codes",
               sent_count, PHASES + 5);
      $display("%0d pages placed, %0d placements found no fitting hole",
               grant_count, refusal_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("fit_policy_hole_allocator test passed");
      end else begin
         $display("fit_policy_hole_allocator test failed");
      end
      $finish;
   end

endmodule
